FILE: hdl/lceg_pkg.sv
// Shared types, constants and helper functions for the LED colour effect generator.
// No dependencies; imported by the top level.
`default_nettype none

package lceg_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_BASE_RED   = 3'd1,
    REG_BASE_GREEN = 3'd2,
    REG_BASE_BLUE  = 3'd3,
    REG_PERIOD     = 3'd4,
    REG_MIN_LIGHT  = 3'd5,
    REG_MAX_LIGHT  = 3'd6
  } cfg_reg_t;

  // Effect modes
  typedef enum logic [1:0] {
    MODE_SOLID   = 2'd0,
    MODE_HUE     = 2'd1,
    MODE_RAINBOW = 2'd2,
    MODE_BLANK   = 2'd3
  } mode_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned PER_W      = 13;

  // Hue in 1/64 degree
  localparam logic [15:0] HUE_FULL   = 16'd23040;
  localparam logic [15:0] HUE_SECTOR = 16'd3840;

  // Reciprocals: floor(n/100) = (n*M100)>>30 for n < 2^23,
  // floor(x/125) = (x*M125)>>29 for x < 2^22
  localparam logic [23:0] M100 = 24'd10737419;
  localparam logic [22:0] M125 = 23'd4294968;

  // floor(x/10000) = (x*M10000)>>45 for every 32-bit x
  localparam logic [31:0] M10000 = 32'd3518437209;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Saturate a percent level to 100
  function automatic logic [6:0] sat100(input logic [6:0] v);
    return (v > 7'd100) ? 7'd100 : v;
  endfunction

  function automatic logic [63:0] one_minus(input logic [63:0] y);
    return (y >= Q30_ONE) ? 64'd0 : (Q30_ONE - y);
  endfunction

  // Cosine of angle x (Q2.30 radians) by Horner series, result Q16.
  // Evaluated at elaboration only.
  function automatic logic [16:0] cos_q16(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] f;
    x2 = (x * x) >> 30;
    f  = one_minus(x2 / 64'd132);
    f  = one_minus(((x2 * f) >> 30) / 64'd90);
    f  = one_minus(((x2 * f) >> 30) / 64'd56);
    f  = one_minus(((x2 * f) >> 30) / 64'd30);
    f  = one_minus(((x2 * f) >> 30) / 64'd12);
    f  = one_minus(((x2 * f) >> 30) / 64'd2);
    return f[30:14];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lceg_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Carries a valid bit and a sideband tag alongside each operand pair.
`default_nettype none

module lceg_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 13,
  parameter int unsigned TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_num,
  input  wire logic [VW-1:0] in_den,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_valid,
  output logic [DW-1:0]      out_quot,
  output logic [VW-1:0]      out_rem,
  output logic [TW-1:0]      out_tag
);

  logic          vld [1:DW];
  logic [VW-1:0] rem [1:DW];
  logic [DW-1:0] num [1:DW];
  logic [VW-1:0] den [1:DW];
  logic [TW-1:0] tag [1:DW];

  for (genvar s = 1; s <= DW; s++) begin : g_stage
    logic          pv;
    logic [VW-1:0] pr;
    logic [DW-1:0] pn;
    logic [VW-1:0] pd;
    logic [TW-1:0] pt;
    logic [VW:0]   trial;
    logic          ge;

    if (s == 1) begin : g_first
      assign pv = in_valid;
      assign pr = '0;
      assign pn = in_num;
      assign pd = in_den;
      assign pt = in_tag;
    end else begin : g_next
      assign pv = vld[s-1];
      assign pr = rem[s-1];
      assign pn = num[s-1];
      assign pd = den[s-1];
      assign pt = tag[s-1];
    end

    // Shift in the next dividend bit and trial-subtract
    assign trial = {pr, pn[DW-1]};
    assign ge    = trial >= {1'b0, pd};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem[s] <= ge ? VW'(trial - {1'b0, pd}) : trial[VW-1:0];
      num[s] <= {pn[DW-2:0], ge};
      den[s] <= pd;
      tag[s] <= pt;
    end
  end

  assign out_valid = vld[DW];
  assign out_quot  = num[DW];
  assign out_rem   = rem[DW];
  assign out_tag   = tag[DW];

endmodule

`default_nettype wire

FILE: hdl/led_color_effect_generator_unit.sv
// Top level of the LED colour effect generator: time moduli, cosine pulse,
// hue wheel and channel scaling. Depends on lceg_pkg and lceg_div.
//
// Channel   Handshake             Payload
// input     start / busy          elapsed_ms, column
// result    done (one cycle)      red_out, green_out, blue_out
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction enters per cycle; busy stays low outside reset.
// Each transaction passes the two chains of one-bit divider stages (time modulo,
// then phase) and then the registered stages B to G.
// Reset clears all valid bits and restores the register defaults.
// Results are presented for one cycle on done; the receiver cannot stall.
`default_nettype none

module led_color_effect_generator_unit
  import lceg_pkg::*;
#(
  parameter int unsigned COLUMNS         = 21,
  parameter int unsigned COS_TABLE_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [31:0]           elapsed_ms,
  input  wire logic [5:0]            column,
  output logic                       done,
  output logic [7:0]                 red_out,
  output logic [7:0]                 green_out,
  output logic [7:0]                 blue_out,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PH_W = $clog2(4 * COS_TABLE_DEPTH);
  localparam int unsigned AW   = $clog2(COS_TABLE_DEPTH);
  localparam int unsigned DW2  = PER_W + PH_W;
  // Pads the three reciprocal stages out to the 32-stage time divider
  localparam int unsigned HM_DLY = 29;

  // Configuration registers
  mode_t            mode;
  logic [6:0]       base_red;
  logic [6:0]       base_green;
  logic [6:0]       base_blue;
  logic [PER_W-1:0] period;
  logic [6:0]       min_light;
  logic [6:0]       max_light;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // Take configuration transactions; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SOLID;
      base_red   <= 7'd0;
      base_green <= 7'd0;
      base_blue  <= 7'd0;
      period     <= 13'd2000;
      min_light  <= 7'd0;
      max_light  <= 7'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:       mode       <= mode_t'(cfg_data[1:0]);
        REG_BASE_RED:   base_red   <= cfg_data[6:0];
        REG_BASE_GREEN: base_green <= cfg_data[6:0];
        REG_BASE_BLUE:  base_blue  <= cfg_data[6:0];
        REG_PERIOD:     period     <= cfg_data;
        REG_MIN_LIGHT:  min_light  <= cfg_data[6:0];
        REG_MAX_LIGHT:  max_light  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Clamp the pulse period into 500..5000 ms
  logic [PER_W-1:0] per_clamp;
  always_comb begin
    if (period < 13'd500) begin
      per_clamp = 13'd500;
    end else if (period > 13'd5000) begin
      per_clamp = 13'd5000;
    end else begin
      per_clamp = period;
    end
  end

  // Constant tables: column hue offset and quarter-wave cosine
  logic [14:0] cp_tab  [64];
  logic [16:0] cos_tab [COS_TABLE_DEPTH];

  for (genvar k = 0; k < 64; k++) begin : g_cp
    localparam int unsigned CPV = ((k * 23040) / COLUMNS) % 23040;
    assign cp_tab[k] = CPV[14:0];
  end

  for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_cos
    localparam logic [63:0] XK = (64'(k) * HALF_PI_Q30) / 64'(COS_TABLE_DEPTH);
    assign cos_tab[k] = cos_q16(XK);
  end

  // Elapsed time modulo pulse period, and modulo the hue cycle
  logic             tm_valid;
  logic [PER_W-1:0] tm_rem;
  logic [5:0]       tm_col;
  logic [13:0]      hm_rem;

  lceg_div #(.DW(32), .VW(PER_W), .TW(6)) u_tmod (
    .clk(clk), .rst(rst),
    .in_valid(start && !busy), .in_num(elapsed_ms), .in_den(per_clamp),
    .in_tag(column),
    .out_valid(tm_valid), .out_quot(), .out_rem(tm_rem), .out_tag(tm_col)
  );

  // Hue cycle modulo by reciprocal: quotient, remainder, then in rainbow mode fold 10000 to 5000
  logic [13:0]                 hm_x1;
  logic [18:0]                 hm_q1;
  logic [13:0]                 hm_r2;
  logic [13:0]                 hm_r3;
  logic [63:0]                 hm_prod;
  logic [32:0]                 hm_qm;
  logic [HM_DLY-1:0][13:0]     hm_dly;

  assign hm_prod = 64'(elapsed_ms) * 64'(M10000);
  assign hm_qm   = 33'(hm_q1) * 33'd10000;

  always_ff @(posedge clk) begin
    hm_x1  <= elapsed_ms[13:0];
    hm_q1  <= hm_prod[63:45];
    hm_r2  <= hm_x1 - hm_qm[13:0];
    hm_r3  <= ((mode == MODE_RAINBOW) && (hm_r2 >= 14'd5000)) ? (hm_r2 - 14'd5000) : hm_r2;
    hm_dly <= {hm_dly[HM_DLY-2:0], hm_r3};
  end

  assign hm_rem = hm_dly[HM_DLY-1];

  // Phase within the period, in quarter-wave table steps
  logic           ph_valid;
  logic [DW2-1:0] ph_quot;
  logic [19:0]    ph_tag;
  logic [PH_W-1:0] ph_p;

  lceg_div #(.DW(DW2), .VW(PER_W), .TW(20)) u_phase (
    .clk(clk), .rst(rst),
    .in_valid(tm_valid),
    .in_num(DW2'(tm_rem) * DW2'(4 * COS_TABLE_DEPTH)),
    .in_den(per_clamp), .in_tag({tm_col, hm_rem}),
    .out_valid(ph_valid), .out_quot(ph_quot), .out_rem(), .out_tag(ph_tag)
  );

  assign ph_p = ph_quot[PH_W-1:0];

  // Stage B: quadrant split, table address, hue product
  logic            b_valid;
  logic [1:0]      b_q;
  logic [AW-1:0]   b_addr;
  logic            b_czero;
  logic [21:0]     b_x;
  logic [14:0]     b_cp;
  logic [1:0]      q_next;
  logic [PH_W-1:0] j_next;

  always_comb begin
    if (ph_p >= PH_W'(3 * COS_TABLE_DEPTH)) begin
      q_next = 2'd3;
      j_next = ph_p - PH_W'(3 * COS_TABLE_DEPTH);
    end else if (ph_p >= PH_W'(2 * COS_TABLE_DEPTH)) begin
      q_next = 2'd2;
      j_next = ph_p - PH_W'(2 * COS_TABLE_DEPTH);
    end else if (ph_p >= PH_W'(COS_TABLE_DEPTH)) begin
      q_next = 2'd1;
      j_next = ph_p - PH_W'(COS_TABLE_DEPTH);
    end else begin
      q_next = 2'd0;
      j_next = ph_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= ph_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_q     <= q_next;
    b_addr  <= q_next[0] ? AW'(PH_W'(COS_TABLE_DEPTH) - j_next) : AW'(j_next);
    b_czero <= q_next[0] && (j_next == '0);
    b_x     <= 22'(ph_tag[13:0]) * ((mode == MODE_RAINBOW) ? 22'd576 : 22'd288);
    b_cp    <= cp_tab[ph_tag[19:14]];
  end

  // Stage C: cosine lookup, raised cosine, hue division by 125
  logic        c_valid;
  logic [16:0] c_rc;
  logic [14:0] c_hq;
  logic [14:0] c_cp;
  logic [16:0] cos_val;
  logic [17:0] rc_sum;
  logic [44:0] hq_prod;

  assign cos_val = b_czero ? 17'd0 : cos_tab[b_addr];
  assign rc_sum  = ((b_q == 2'd0) || (b_q == 2'd3)) ? (18'd65536 + 18'(cos_val))
                                                    : (18'd65536 - 18'(cos_val));
  assign hq_prod = 45'(b_x) * 45'(M125);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_rc <= rc_sum[17:1];
    c_hq <= hq_prod[43:29];
    c_cp <= b_cp;
  end

  // Stage D: intensity numerator, final hue
  logic        d_valid;
  logic [22:0] d_num;
  logic [14:0] d_hue;
  logic [24:0] num_next;
  logic [15:0] wrap_sum;

  assign num_next = 25'(sat100(min_light)) * 25'(18'd65536 - 18'(c_rc))
                  + 25'(sat100(max_light)) * 25'(c_rc);
  assign wrap_sum = (c_cp >= c_hq) ? (16'(c_cp) - 16'(c_hq))
                                   : (16'(c_cp) + HUE_FULL - 16'(c_hq));

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_num <= num_next[22:0];
    d_hue <= (mode == MODE_RAINBOW) ? wrap_sum[14:0] : c_hq;
  end

  // Stage E: intensity divide by 100, hue sector split
  logic        e_valid;
  logic [16:0] e_int;
  logic [2:0]  e_sec;
  logic [11:0] e_f;
  logic [46:0] int_prod;
  logic [2:0]  sec_next;
  logic [15:0] f_next;

  assign int_prod = 47'(d_num) * 47'(M100);

  always_comb begin
    if (16'(d_hue) >= 16'd19200) begin
      sec_next = 3'd5;
      f_next   = 16'(d_hue) - 16'd19200;
    end else if (16'(d_hue) >= 16'd15360) begin
      sec_next = 3'd4;
      f_next   = 16'(d_hue) - 16'd15360;
    end else if (16'(d_hue) >= 16'd11520) begin
      sec_next = 3'd3;
      f_next   = 16'(d_hue) - 16'd11520;
    end else if (16'(d_hue) >= 16'd7680) begin
      sec_next = 3'd2;
      f_next   = 16'(d_hue) - 16'd7680;
    end else if (16'(d_hue) >= HUE_SECTOR) begin
      sec_next = 3'd1;
      f_next   = 16'(d_hue) - HUE_SECTOR;
    end else begin
      sec_next = 3'd0;
      f_next   = 16'(d_hue);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    e_int <= int_prod[46:30];
    e_sec <= sec_next;
    e_f   <= f_next[11:0];
  end

  // Stage F: raw colour from hue wheel or base levels
  logic        f_valid;
  logic [7:0]  f_r;
  logic [7:0]  f_g;
  logic [7:0]  f_b;
  logic [16:0] f_int;
  logic [15:0] up_prod;
  logic [15:0] dn_prod;
  logic [7:0]  up;
  logic [7:0]  dn;
  logic [7:0]  hr;
  logic [7:0]  hg;
  logic [7:0]  hb;
  logic [8:0]  sr;
  logic [8:0]  sg;
  logic [8:0]  sb;

  // 255/3840 reduces to 17/256
  assign up_prod = 16'(e_f) * 16'd17;
  assign dn_prod = (HUE_SECTOR - 16'(e_f)) * 16'd17;
  assign up      = up_prod[15:8];
  assign dn      = dn_prod[15:8];
  assign sr      = 9'(sat100(base_red)) * 9'd5;
  assign sg      = 9'(sat100(base_green)) * 9'd5;
  assign sb      = 9'(sat100(base_blue)) * 9'd5;

  always_comb begin
    unique case (e_sec)
      3'd0:    begin hr = 8'd255; hg = up;     hb = 8'd0;   end
      3'd1:    begin hr = dn;     hg = 8'd255; hb = 8'd0;   end
      3'd2:    begin hr = 8'd0;   hg = 8'd255; hb = up;     end
      3'd3:    begin hr = 8'd0;   hg = dn;     hb = 8'd255; end
      3'd4:    begin hr = up;     hg = 8'd0;   hb = 8'd255; end
      default: begin hr = 8'd255; hg = 8'd0;   hb = dn;     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mode == MODE_SOLID) begin
      f_r <= sr[8:1];
      f_g <= sg[8:1];
      f_b <= sb[8:1];
    end else begin
      f_r <= hr;
      f_g <= hg;
      f_b <= hb;
    end
    f_int <= e_int;
  end

  // Stage G: scale by intensity in solid and hue modes, and present the result
  logic [24:0] pr;
  logic [24:0] pg;
  logic [24:0] pb;

  assign pr = 25'(f_r) * 25'(f_int);
  assign pg = 25'(f_g) * 25'(f_int);
  assign pb = 25'(f_b) * 25'(f_int);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    unique case (mode)
      MODE_SOLID, MODE_HUE: begin
        red_out   <= pr[23:16];
        green_out <= pg[23:16];
        blue_out  <= pb[23:16];
      end
      MODE_RAINBOW: begin
        red_out   <= f_r;
        green_out <= f_g;
        blue_out  <= f_b;
      end
      default: begin
        red_out   <= 8'd0;
        green_out <= 8'd0;
        blue_out  <= 8'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/lceg_checker.sv
// Port-level checker for the LED colour effect generator, bound to the top level.
// Depends on lceg_pkg for the period width PER_W.
`default_nettype none

module lceg_checker
  import lceg_pkg::*;
#(
  parameter int unsigned COS_TABLE_DEPTH = 256
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic cfg_ready
);

  localparam int unsigned LAT = 38 + PER_W + $clog2(4 * COS_TABLE_DEPTH);

  // A result only appears for a transaction accepted the fixed latency earlier
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching accepted transaction");

  // Reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result emerged straight after reset");

  // The block takes a transaction and a register write in every cycle
  a_always_open: assert property (@(posedge clk) disable iff (rst)
    !busy && cfg_ready)
    else $error("block refused a transaction");

endmodule

bind led_color_effect_generator_unit lceg_checker #(
  .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
) u_lceg_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .cfg_ready(cfg_ready)
);

`default_nettype wire
